// ===== src/tccs_pkg.sv =====
// ============================================================================
// tccs_pkg: shared types and constants for the text console cursor/scroll unit
// Command encodings, character codes, the queued command word and the
// result word passed from the back end to the top level.
// ============================================================================
package tccs_pkg;

    // Fixed field widths of the ports and the queue depth
    localparam int FUNC_W      = 2;
    localparam int CH_W        = 8;
    localparam int COLOR_W     = 4;
    localparam int INDEX_W     = 11;
    localparam int POS_W       = 11;
    localparam int CELL_W      = 16;
    localparam int QUEUE_DEPTH = 2;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Character codes that act
    localparam logic [CH_W-1:0] CH_BS       = 8'h08;
    localparam logic [CH_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CH_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CH_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CH_W-1:0] CH_PRINT_HI = 8'h7F;

    // White-on-black space
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    // Classified operation carried through the queue
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PRINT,
        OP_BS,
        OP_TAB,
        OP_CR,
        OP_LF,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [CH_W-1:0]        ch;
        logic [2*COLOR_W-1:0]   attr;
        logic [INDEX_W-1:0]     index;
    } cmd_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_BLANK,
        S_CLEAR
    } back_state_t;

    typedef struct packed {
        logic                done;
        logic [POS_W-1:0]    cursor_pos;
        logic [CELL_W-1:0]   cell_data;
        logic                scrolled;
    } result_t;

endpackage

// ===== src/tccs_front.sv =====
// ============================================================================
// tccs_front: command intake and classification
// Accepts a word when the queue has room and the reset fill is done, decodes
// the function and character into one operation and pushes it to the queue.
// ============================================================================
module tccs_front #(
    parameter int CELL_COUNT = 2000
) (
    input  logic                           start,
    input  logic [tccs_pkg::FUNC_W-1:0]    func,
    input  logic [tccs_pkg::CH_W-1:0]      ch,
    input  logic [tccs_pkg::COLOR_W-1:0]   back_color,
    input  logic [tccs_pkg::COLOR_W-1:0]   fore_color,
    input  logic [tccs_pkg::INDEX_W-1:0]   cell_index,
    input  logic                           fifo_full,
    input  logic                           init_active,
    output logic                           busy,
    output logic                           push,
    output tccs_pkg::cmd_t                 cmd
);
    import tccs_pkg::*;

    op_t op;

    // Intake handshake: hold off while the queue is full or memory is filling
    assign busy = fifo_full | init_active;
    assign push = start & ~busy;

    // Classify the incoming word
    always_comb
    begin
        op = OP_NOP;
        case (func)
            FUNC_PUT:
            begin
                case (ch) inside
                    CH_BS:                     op = OP_BS;
                    CH_TAB:                    op = OP_TAB;
                    CH_LF:                     op = OP_LF;
                    CH_CR:                     op = OP_CR;
                    [CH_PRINT_LO:CH_PRINT_HI]: op = OP_PRINT;
                    default:                   op = OP_NOP;
                endcase
            end
            FUNC_CLEAR:
            begin
                op = OP_CLEAR;
            end
            FUNC_READ:
            begin
                // out-of-range reads return zero and change nothing
                if (32'(cell_index) < CELL_COUNT)
                begin
                    op = OP_READ;
                end
            end
            default:
            begin
                op = OP_NOP;
            end
        endcase
    end

    assign cmd.op    = op;
    assign cmd.ch    = ch;
    assign cmd.attr  = {back_color, fore_color};
    assign cmd.index = cell_index;

endmodule

// ===== src/tccs_cmd_fifo.sv =====
// ============================================================================
// tccs_cmd_fifo: short command queue
// Decouples intake from execution; the head word is visible while not empty.
// ============================================================================
module tccs_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tccs_pkg::cmd_t  cmd_in,
    input  logic            pop,
    output tccs_pkg::cmd_t  cmd_out,
    output logic            empty,
    output logic            full
);
    import tccs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == DEPTH_CNT);
    assign cmd_out = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== src/tccs_back.sv =====
// ============================================================================
// tccs_back: command execution
// Owns the cursor, the screen memory and the scroll offset. The screen is
// a ring of rows: a scroll moves the top-row offset and blanks one row.
// ============================================================================
module tccs_back #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fifo_empty,
    input  tccs_pkg::cmd_t     head,
    output logic               pop,
    output logic               init_active,
    output tccs_pkg::result_t  result
);
    import tccs_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int AWX        = AW + 1;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int COLX_W     = $clog2(COLUMNS + TAB_WIDTH);
    localparam int PH_W       = $clog2(TAB_WIDTH);

    localparam logic [AW-1:0]     LAST_BASE    = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0]     ROW_STEP     = AW'(COLUMNS);
    localparam logic [AW-1:0]     LAST_CELL    = AW'(CELL_COUNT - 1);
    localparam logic [AWX-1:0]    CELL_COUNT_X = AWX'(CELL_COUNT);
    localparam logic [AWX-1:0]    ROW_STEP_X   = AWX'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS - 1);
    localparam logic [COLX_W-1:0] COLUMNS_X    = COLX_W'(COLUMNS);
    localparam logic [COLX_W-1:0] TAB_X        = COLX_W'(TAB_WIDTH);
    localparam logic [PH_W-1:0]   LAST_PHASE   = PH_W'(TAB_WIDTH - 1);

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [PH_W-1:0]   phase_reg;
    logic [PH_W-1:0]   phase_next;
    logic [AW-1:0]     row_base_reg;
    logic [AW-1:0]     row_base_next;
    logic [AW-1:0]     off_reg;
    logic [AW-1:0]     off_next;
    logic [AW-1:0]     sweep_reg;
    logic [AW-1:0]     sweep_next;
    logic [COL_W-1:0]  blank_cnt_reg;
    logic [COL_W-1:0]  blank_cnt_next;
    logic              done_reg;
    logic              done_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [CELL_W-1:0] data_reg;
    logic [CELL_W-1:0] data_next;
    logic              scrolled_reg;
    logic              scrolled_next;

    // Screen memory
    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              rd_en;

    // Address and cursor step logic
    logic [AW-1:0]     cur_lin;
    logic [AW-1:0]     lin_sel;
    logic [AWX-1:0]    phys_sum;
    logic [AW-1:0]     phys;
    logic [COLX_W-1:0] colx;
    logic [COLX_W-1:0] step_col;
    logic [PH_W-1:0]   step_phase;
    logic              step_row;
    logic              wrap;
    logic [COL_W-1:0]  new_col;
    logic [PH_W-1:0]   new_phase;
    logic              adv_row;
    logic              scroll;
    logic [AW-1:0]     new_base;
    logic [AW-1:0]     new_pos;
    logic [AWX-1:0]    off_sum;
    logic [AW-1:0]     off_scrolled;
    logic              fill_last;
    logic              blank_last;

    assign init_active = (state_reg == S_INIT);
    assign fill_last   = (sweep_reg == LAST_CELL);
    assign blank_last  = (blank_cnt_reg == LAST_COL);

    // Logical to physical address through the top-row offset
    assign cur_lin  = row_base_reg + AW'(col_reg);
    assign lin_sel  = (cmd_reg.op == OP_READ) ? AW'(cmd_reg.index) : cur_lin;
    assign phys_sum = AWX'(lin_sel) + AWX'(off_reg);
    assign phys     = (phys_sum >= CELL_COUNT_X) ? AW'(phys_sum - CELL_COUNT_X)
                                                 : AW'(phys_sum);

    // Offset after a scroll: the old top row becomes the bottom row
    assign off_sum      = AWX'(off_reg) + ROW_STEP_X;
    assign off_scrolled = (off_sum >= CELL_COUNT_X) ? '0 : AW'(off_sum);

    // Column step; phase tracks column modulo the tab width
    assign colx = COLX_W'(col_reg);

    always_comb
    begin
        step_col   = colx;
        step_phase = phase_reg;
        step_row   = 1'b0;
        case (cmd_reg.op)
            OP_PRINT:
            begin
                step_col   = colx + 1'b1;
                step_phase = (phase_reg == LAST_PHASE) ? '0 : phase_reg + 1'b1;
            end
            OP_BS:
            begin
                if (col_reg != '0)
                begin
                    step_col   = colx - 1'b1;
                    step_phase = (phase_reg == '0) ? LAST_PHASE : phase_reg - 1'b1;
                end
            end
            OP_TAB:
            begin
                step_col   = colx + TAB_X - COLX_W'(phase_reg);
                step_phase = '0;
            end
            OP_CR:
            begin
                step_col   = '0;
                step_phase = '0;
            end
            OP_LF:
            begin
                step_col   = '0;
                step_phase = '0;
                step_row   = 1'b1;
            end
            default:
            begin
                step_col = colx;
            end
        endcase
    end

    // Column wrap, row advance and scroll detection
    assign wrap      = (step_col >= COLUMNS_X);
    assign new_col   = wrap ? '0 : COL_W'(step_col);
    assign new_phase = wrap ? '0 : step_phase;
    assign adv_row   = step_row | wrap;
    assign scroll    = adv_row && (row_base_reg == LAST_BASE);
    assign new_base  = (adv_row && !scroll) ? row_base_reg + ROW_STEP : row_base_reg;
    assign new_pos   = new_base + AW'(new_col);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd_reg.op == OP_CLEAR)
                begin
                    state_next = S_CLEAR;
                end
                else if (cmd_reg.op == OP_READ)
                begin
                    state_next = S_READ;
                end
                else if (scroll)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            S_BLANK:
            begin
                if (blank_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                if (fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs per state
    always_comb
    begin
        pop            = 1'b0;
        cmd_next       = cmd_reg;
        col_next       = col_reg;
        phase_next     = phase_reg;
        row_base_next  = row_base_reg;
        off_next       = off_reg;
        sweep_next     = sweep_reg;
        blank_cnt_next = blank_cnt_reg;
        done_next      = 1'b0;
        pos_next       = pos_reg;
        data_next      = data_reg;
        scrolled_next  = scrolled_reg;
        mem_we         = 1'b0;
        mem_waddr      = sweep_reg;
        mem_wdata      = BLANK_CELL;
        rd_en          = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                mem_we     = 1'b1;
                sweep_next = fill_last ? '0 : sweep_reg + 1'b1;
            end
            S_IDLE:
            begin
                pop = ~fifo_empty;
                if (!fifo_empty)
                begin
                    cmd_next = head;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg.op)
                    OP_CLEAR:
                    begin
                        col_next      = '0;
                        phase_next    = '0;
                        row_base_next = '0;
                        off_next      = '0;
                        sweep_next    = '0;
                    end
                    OP_READ:
                    begin
                        rd_en = 1'b1;
                    end
                    default:
                    begin
                        // store the character before the cursor moves
                        if (cmd_reg.op == OP_PRINT)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = phys;
                            mem_wdata = {cmd_reg.attr, cmd_reg.ch};
                        end
                        col_next      = new_col;
                        phase_next    = new_phase;
                        row_base_next = new_base;
                        if (scroll)
                        begin
                            off_next       = off_scrolled;
                            sweep_next     = off_reg;
                            blank_cnt_next = '0;
                        end
                        else
                        begin
                            done_next     = 1'b1;
                            pos_next      = POS_W'(new_pos);
                            data_next     = '0;
                            scrolled_next = 1'b0;
                        end
                    end
                endcase
            end
            S_READ:
            begin
                done_next     = 1'b1;
                pos_next      = POS_W'(cur_lin);
                data_next     = rd_data_reg;
                scrolled_next = 1'b0;
            end
            S_BLANK:
            begin
                mem_we         = 1'b1;
                sweep_next     = sweep_reg + 1'b1;
                blank_cnt_next = blank_cnt_reg + 1'b1;
                if (blank_last)
                begin
                    done_next     = 1'b1;
                    pos_next      = POS_W'(cur_lin);
                    data_next     = '0;
                    scrolled_next = 1'b1;
                end
            end
            S_CLEAR:
            begin
                mem_we     = 1'b1;
                sweep_next = fill_last ? '0 : sweep_reg + 1'b1;
                if (fill_last)
                begin
                    done_next     = 1'b1;
                    pos_next      = POS_W'(cur_lin);
                    data_next     = '0;
                    scrolled_next = 1'b0;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            col_reg       <= '0;
            phase_reg     <= '0;
            row_base_reg  <= '0;
            off_reg       <= '0;
            sweep_reg     <= '0;
            blank_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            row_base_reg  <= row_base_next;
            off_reg       <= off_next;
            sweep_reg     <= sweep_next;
            blank_cnt_reg <= blank_cnt_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        data_reg     <= data_next;
        scrolled_reg <= scrolled_next;
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[phys];
        end
    end

    assign result.done       = done_reg;
    assign result.cursor_pos = pos_reg;
    assign result.cell_data  = data_reg;
    assign result.scrolled   = scrolled_reg;

endmodule

// ===== src/text_console_cursor_scroll_unit.sv =====
// ============================================================================
// text_console_cursor_scroll_unit: text console engine top level
// Screen of ROWS x COLUMNS character cells with cursor, wrap and scroll.
// ============================================================================
// Usage:
//   Command channel: drive func/ch/back_color/fore_color/cell_index with
//   start; the word is taken on a clock edge where start is high and busy
//   is low. A two-word queue lets a new word in while another executes.
//   Result channel: done pulses for one cycle with cursor_pos, cell_data
//   and scrolled. One result per command, in command order. There is no
//   back-pressure on results; the receiver must take each on its strobe.
//   Sequence: the back end takes a word from the queue while idle, executes
//   it and registers the result; a cell read adds a registered memory read,
//   a step that scrolls then blanks one row, and a clear sweeps the whole
//   memory. The back end takes no new word until it is done with the last.
//   Reset: cursor homes and the screen memory is filled with blanks, all
//   ROWS*COLUMNS cells (2000 by default), one cell per cycle; busy is high
//   until the fill completes.
// ============================================================================
module text_console_cursor_scroll_unit #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tccs_pkg::FUNC_W-1:0]    func,
    input  logic [tccs_pkg::CH_W-1:0]      ch,
    input  logic [tccs_pkg::COLOR_W-1:0]   back_color,
    input  logic [tccs_pkg::COLOR_W-1:0]   fore_color,
    input  logic [tccs_pkg::INDEX_W-1:0]   cell_index,
    output logic                           done,
    output logic [tccs_pkg::POS_W-1:0]     cursor_pos,
    output logic [tccs_pkg::CELL_W-1:0]    cell_data,
    output logic                           scrolled
);
    import tccs_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam logic [POS_W-1:0] LAST_ROW_POS = POS_W'((ROWS - 1) * COLUMNS);

    cmd_t    front_cmd;
    cmd_t    head_cmd;
    result_t result;
    logic    push;
    logic    pop;
    logic    fifo_empty;
    logic    fifo_full;
    logic    init_active;

    // Intake and classification
    tccs_front #(
        .CELL_COUNT (CELL_COUNT)
    ) u_front (
        .start       (start),
        .func        (func),
        .ch          (ch),
        .back_color  (back_color),
        .fore_color  (fore_color),
        .cell_index  (cell_index),
        .fifo_full   (fifo_full),
        .init_active (init_active),
        .busy        (busy),
        .push        (push),
        .cmd         (front_cmd)
    );

    // Command queue
    tccs_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .pop     (pop),
        .cmd_out (head_cmd),
        .empty   (fifo_empty),
        .full    (fifo_full)
    );

    // Execution
    tccs_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_empty  (fifo_empty),
        .head        (head_cmd),
        .pop         (pop),
        .init_active (init_active),
        .result      (result)
    );

    assign done       = result.done;
    assign cursor_pos = result.cursor_pos;
    assign cell_data  = result.cell_data;
    assign scrolled   = result.scrolled;

    // No word enters a full queue or during the reset fill
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!fifo_full && !init_active))
        else $error("command pushed without room");

    // A scroll always leaves the cursor at the start of the last row
    a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && scrolled) |-> (cursor_pos == LAST_ROW_POS))
        else $error("scroll result with cursor off the last row start");

    // Results never come out while the memory is still being filled
    a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_active |-> !done)
        else $error("result during reset fill");

endmodule
